@@ hdl/rce_pkg.sv @@
package rce_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned TIME_W = 32;
  localparam int unsigned COL_W  = 7;

  // Defaults for the top-level parameters.
  localparam int unsigned RING_DEPTH_DEF = 32;
  localparam int unsigned COLUMNS_DEF    = 128;

  // Reset value of the stop threshold register, in microseconds.
  localparam logic [TIME_W-1:0] THRESHOLD_RESET = 32'd100000;

  typedef struct packed {
    logic [TIME_W-1:0] now_us;
    logic              hall_edge;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  column;
    logic [TIME_W-1:0] mean_period_us;
    logic              rotating;
  } out_item_t;

  // Handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

@@ hdl/rotation_column_estimator.sv @@
// Rotation column estimator: a period-averaging tachometer that tells a
// persistence-of-vision display which column to show.
// Input channel (in_valid_i / in_stall_o / in_item_i): each item carries a
// free-running microsecond timestamp and a flag for a sensor falling edge.
// Output channel (out_valid_o / out_stall_i / out_item_o): one result item per
// input item, with the display column, the mean period and a rotating flag.
// The stop threshold is written through cfg_we_i / cfg_wdata_i; the user must
// write it only while idle, as the block itself does not enforce this.
// Items are processed one at a time by a bit-serial divider that yields one
// quotient bit per cycle over W = 32 + max(clog2(RING_DEPTH), clog2(COLUMNS))
// bits (W = 39 at the defaults). An item without a period update runs only
// the column division, which is skipped with a zero mean; an edge that stores
// a period first runs the divider for the mean, then the column division.
// The result sits in an output register, so the next item is taken while an
// earlier result is still stalled; only the finished item after that waits.
// Reset clears the period ring (through a wrap flag, not a sweep), the sum,
// the edge history and the output valid, and loads the default threshold.
module rotation_column_estimator #(
  parameter int unsigned RING_DEPTH = rce_pkg::RING_DEPTH_DEF,
  parameter int unsigned COLUMNS    = rce_pkg::COLUMNS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  rce_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rce_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [rce_pkg::TIME_W-1:0] cfg_wdata_i
);

  localparam int unsigned TIME_W = rce_pkg::TIME_W;
  localparam int unsigned COL_W  = rce_pkg::COL_W;
  localparam int unsigned SLOT_W = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W  = TIME_W + $clog2(RING_DEPTH);
  localparam int unsigned PROD_W = TIME_W + $clog2(COLUMNS);
  localparam int unsigned DVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
  localparam int unsigned RES_W  = $clog2(COLUMNS);

  // The sequencer walks through these steps for every item.
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_MEAN  = 6'b000100,
    S_CHECK = 6'b001000,
    S_COL   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Long-lived tachometer state.
  logic [TIME_W-1:0] last_edge_q, last_edge_d;
  logic              edge_seen_q, edge_seen_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              wrapped_q, wrapped_d;
  logic [TIME_W-1:0] mean_q, mean_d;
  logic [TIME_W-1:0] thresh_q, thresh_d;

  // Per-item working registers.
  logic [TIME_W-1:0] period_q, period_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [RES_W-1:0]  col_q, col_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  rce_pkg::out_item_t out_item_q, out_item_d;

  // Period ring. A slot is read back only just before it is overwritten, and
  // slots are filled in order, so a slot holds a real period exactly when the
  // write pointer has wrapped at least once; before that it reads as zero.
  logic [TIME_W-1:0] ring_mem [RING_DEPTH];
  logic [TIME_W-1:0] ring_rd_q;
  logic              ring_we;

  logic                 accept;
  logic                 out_free;
  logic [TIME_W-1:0]    elapsed;
  logic [TIME_W-1:0]    old_period;

  logic                 div_start;
  logic [DVD_W-1:0]     div_dividend;
  logic [TIME_W-1:0]    div_divisor;
  rce_pkg::div_status_t div_status;
  logic [DVD_W-1:0]     div_quot;
  logic [RES_W-1:0]     div_resid;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // An edge in this item restarts the elapsed time at zero.
  assign elapsed    = in_item_i.hall_edge ? '0 : in_item_i.now_us - last_edge_q;
  assign old_period = wrapped_q ? ring_rd_q : '0;

  always_comb begin
    state_d      = state_q;
    last_edge_d  = last_edge_q;
    edge_seen_d  = edge_seen_q;
    sum_d        = sum_q;
    slot_d       = slot_q;
    wrapped_d    = wrapped_q;
    mean_d       = mean_q;
    period_d     = period_q;
    prod_d       = prod_q;
    col_d        = col_q;
    out_valid_d  = out_valid_q;
    out_item_d   = out_item_q;
    ring_we      = 1'b0;
    div_start    = 1'b0;
    div_dividend = DVD_W'(prod_q);
    div_divisor  = mean_q;
    thresh_d     = cfg_we_i ? cfg_wdata_i : thresh_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          period_d = in_item_i.now_us - last_edge_q;
          prod_d   = PROD_W'(elapsed) * PROD_W'(COLUMNS);
          if (in_item_i.hall_edge) begin
            last_edge_d = in_item_i.now_us;
            edge_seen_d = 1'b1;
          end
          // Only an edge after an earlier edge stores a new period.
          if (in_item_i.hall_edge && edge_seen_q) begin
            state_d = S_READ;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_READ: begin
        // The slot's old period is now in ring_rd_q.
        sum_d        = sum_q - SUM_W'(old_period) + SUM_W'(period_q);
        ring_we      = 1'b1;
        if (slot_q == SLOT_W'(RING_DEPTH - 1)) begin
          slot_d    = '0;
          wrapped_d = 1'b1;
        end else begin
          slot_d = slot_q + 1'b1;
        end
        div_start    = 1'b1;
        div_dividend = DVD_W'(sum_d);
        div_divisor  = TIME_W'(RING_DEPTH);
        state_d      = S_MEAN;
      end
      S_MEAN: begin
        if (div_status.done) begin
          mean_d  = div_quot[TIME_W-1:0];
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        // A zero mean means no usable period yet: column zero, no division.
        if (mean_q == '0) begin
          col_d   = '0;
          state_d = S_FIN;
        end else begin
          div_start = 1'b1;
          state_d   = S_COL;
        end
      end
      S_COL: begin
        if (div_status.done) begin
          col_d   = div_resid;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d               = 1'b1;
          out_item_d.column         = COL_W'(col_q);
          out_item_d.mean_period_us = mean_q;
          out_item_d.rotating       = edge_seen_q && (mean_q < thresh_q);
          state_d                   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_edge_q <= '0;
      edge_seen_q <= 1'b0;
      sum_q       <= '0;
      slot_q      <= '0;
      wrapped_q   <= 1'b0;
      mean_q      <= '0;
      thresh_q    <= rce_pkg::THRESHOLD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_edge_q <= last_edge_d;
      edge_seen_q <= edge_seen_d;
      sum_q       <= sum_d;
      slot_q      <= slot_d;
      wrapped_q   <= wrapped_d;
      mean_q      <= mean_d;
      thresh_q    <= thresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q   <= period_d;
    prod_q     <= prod_d;
    col_q      <= col_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= period_q;
    end
    ring_rd_q <= ring_mem[slot_q];
  end

  rce_div #(
    .DVD_W   (DVD_W),
    .COLUMNS (COLUMNS)
  ) u_rce_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_status),
    .quot_o     (div_quot),
    .resid_o    (div_resid)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ hdl/rce_div.sv @@
// Bit-serial restoring divider. One quotient bit is produced per cycle,
// most significant first. Alongside the quotient it keeps the quotient
// modulo COLUMNS, folded in one bit at a time.
module rce_div #(
  parameter int unsigned DVD_W   = 40,
  parameter int unsigned COLUMNS = rce_pkg::COLUMNS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [DVD_W-1:0]             dividend_i,
  input  logic [rce_pkg::TIME_W-1:0]   divisor_i,
  output rce_pkg::div_status_t         status_o,
  output logic [DVD_W-1:0]             quot_o,
  output logic [$clog2(COLUMNS)-1:0]   resid_o
);

  localparam int unsigned TIME_W = rce_pkg::TIME_W;
  localparam int unsigned CNT_W  = $clog2(DVD_W + 1);
  localparam int unsigned RES_W  = $clog2(COLUMNS);
  localparam logic [RES_W:0] COLS = (RES_W + 1)'(COLUMNS);

  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [TIME_W-1:0] rem_q, rem_d;
  logic [TIME_W-1:0] dvs_q, dvs_d;
  logic [RES_W-1:0]  res_q, res_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   diff;
  logic              ge;
  logic [RES_W:0]    res_t;
  logic [RES_W:0]    res_sub;

  always_comb begin
    shifted = {rem_q, dvd_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    res_t   = {res_q, ge};
    res_sub = (res_t >= COLS) ? res_t - COLS : res_t;
  end

  always_comb begin
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    res_d  = res_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      quo_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      res_d  = '0;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = dvd_q << 1;
      quo_d = {quo_q[DVD_W-2:0], ge};
      rem_d = ge ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
      res_d = res_sub[RES_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    res_q <= res_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;
  assign resid_o       = res_q;

endmodule

@@ hdl/rce_checker.sv @@
// Port-level checks for the rotation column estimator.
module rce_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input rce_pkg::out_item_t out_item_o
);

  // A stalled result stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed or was dropped");

  // Items are worked one at a time, so acceptance makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  // Without a mean period there is no column to compute.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.mean_period_us == '0) |-> out_item_o.column == '0)
    else $error("nonzero column reported with a zero mean period");

endmodule

bind rotation_column_estimator rce_checker u_rce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
